FILE: src/c8080_pkg.sv
// shared types and constants for the 8080 transfer/add unit
// no dependencies
package c8080_pkg;
    localparam int          ADDR_BITS_DEF = 16;
    localparam logic [16:0] WP_RESET      = 17'd16384;

    localparam logic [1:0] CMD_EXEC  = 2'd0;
    localparam logic [1:0] CMD_HWR   = 2'd1;
    localparam logic [1:0] CMD_HRD   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD2,
        ST_WR2
    } state_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_MOV,
        OP_MVI,
        OP_LXI,
        OP_LDA,
        OP_STA,
        OP_LHLD,
        OP_SHLD,
        OP_LDAX,
        OP_STAX,
        OP_XCHG,
        OP_ADD,
        OP_ADI,
        OP_UNSUP
    } opclass_t;

    function automatic opclass_t decode(input logic [7:0] op);
        opclass_t c;
        c = OP_UNSUP;
        if (op == 8'h00) c = OP_NOP;
        else if (op[7:6] == 2'b01 && op != 8'h76) c = OP_MOV;
        else if ((op & 8'hC7) == 8'h06) c = OP_MVI;
        else if ((op & 8'hCF) == 8'h01) c = OP_LXI;
        else if (op == 8'h3A) c = OP_LDA;
        else if (op == 8'h32) c = OP_STA;
        else if (op == 8'h2A) c = OP_LHLD;
        else if (op == 8'h22) c = OP_SHLD;
        else if (op == 8'h0A || op == 8'h1A) c = OP_LDAX;
        else if (op == 8'h02 || op == 8'h12) c = OP_STAX;
        else if (op == 8'hEB) c = OP_XCHG;
        else if (op[7:4] == 4'h8) c = OP_ADD;
        else if (op == 8'hC6 || op == 8'hCE) c = OP_ADI;
        return c;
    endfunction

    function automatic logic [2:0] op_len(input opclass_t c);
        logic [2:0] l;
        case (c)
            OP_MVI, OP_ADI: l = 3'd2;
            OP_LXI, OP_LDA, OP_STA, OP_LHLD, OP_SHLD: l = 3'd3;
            default: l = 3'd1;
        endcase
        return l;
    endfunction
endpackage

FILE: src/cpu8080_transfer_add_unit.sv
// 8080 data-transfer and add subset with byte memory and host access
// depends on c8080_pkg
// each beat reads or writes memory through one synchronous port; lhld/shld
// make a second access for the second byte. a new beat is accepted only when
// no beat is in flight and the output register is empty or being emptied.
// reset clears registers, flags, pc and sp and restores the default limit;
// memory is undefined until written.
module cpu8080_transfer_add_unit
    import c8080_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  opcode,
    input  logic [7:0]  operand_low,
    input  logic [7:0]  operand_high,
    input  logic [15:0] host_address,
    input  logic [7:0]  host_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  accumulator,
    output logic [4:0]  flags,
    output logic [15:0] program_counter,
    output logic [15:0] pair_bc,
    output logic [15:0] pair_de,
    output logic [15:0] pair_hl,
    output logic [7:0]  read_data,
    output logic        write_refused,
    output logic        unsupported,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata
);
    localparam int DEPTH = 1 << ADDR_BITS;

    logic [7:0] mem [DEPTH];

    logic [7:0]  b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, a_reg;
    logic [4:0]  f_reg;
    logic [15:0] pc_reg, sp_reg;
    logic [16:0] wp_reg;

    // stage 1 holds the accepted beat while memory is read
    logic        s1_reg;
    logic [1:0]  cmd_reg;
    logic [7:0]  op_reg, lo_reg, hi_reg;
    opclass_t    cls_reg;
    state_t      st_reg, st_next;
    logic [7:0]  rdat;
    logic [7:0]  first_reg;
    logic        ref1_reg;

    // output register
    logic        ov_reg;
    logic [7:0]  o_rd_reg;
    logic        o_ref_reg, o_uns_reg;

    logic        fire;
    logic        finish;
    logic        busy;

    assign busy     = s1_reg;
    assign in_ready = !busy && (!ov_reg || out_ready);
    assign fire     = in_valid && in_ready;

    function automatic logic [7:0] reg_by_code(input logic [2:0] code,
        input logic [7:0] b, c, d, e, h, l, a, m);
        logic [7:0] v;
        case (code)
            3'd0: v = b;
            3'd1: v = c;
            3'd2: v = d;
            3'd3: v = e;
            3'd4: v = h;
            3'd5: v = l;
            3'd6: v = m;
            default: v = a;
        endcase
        return v;
    endfunction

    // memory address for first access, computed at accept time
    logic [15:0] addr16_in, maddr_in;
    opclass_t    cls_in;
    logic [2:0]  dst_in;
    logic        mwr_in;
    logic [7:0]  mwd_in;
    logic [15:0] hl, bc, de;

    assign hl = {h_reg, l_reg};
    assign bc = {b_reg, c_reg};
    assign de = {d_reg, e_reg};
    assign addr16_in = {operand_high, operand_low};
    assign cls_in    = decode(opcode);
    assign dst_in    = opcode[5:3];

    always_comb
    begin
        maddr_in = hl;
        mwr_in   = 1'b0;
        mwd_in   = reg_by_code(opcode[2:0], b_reg, c_reg, d_reg, e_reg, h_reg,
                               l_reg, a_reg, 8'h00);
        if (command == CMD_HWR || command == CMD_HRD) begin
            maddr_in = host_address;
            mwr_in   = command == CMD_HWR;
            mwd_in   = host_data;
        end else if (command == CMD_EXEC) begin
            unique case (cls_in)
                OP_MOV:  mwr_in = dst_in == 3'd6 && opcode[2:0] != 3'd6
                                  && ({16'h0, 1'b0} | 17'(hl)) >= wp_reg;
                OP_MVI:  begin
                    mwr_in = dst_in == 3'd6 && 17'(hl) >= wp_reg;
                    mwd_in = operand_low;
                end
                OP_LDA, OP_LHLD: maddr_in = addr16_in;
                OP_STA:  begin
                    maddr_in = addr16_in;
                    mwr_in   = 17'(addr16_in) >= wp_reg;
                    mwd_in   = a_reg;
                end
                OP_SHLD: begin
                    maddr_in = addr16_in;
                    mwr_in   = 17'(addr16_in) >= wp_reg;
                    mwd_in   = l_reg;
                end
                OP_LDAX: maddr_in = opcode[4] ? de : bc;
                OP_STAX: begin
                    maddr_in = opcode[4] ? de : bc;
                    mwr_in   = 17'(maddr_in) >= wp_reg;
                    mwd_in   = a_reg;
                end
                default: ;
            endcase
        end
    end

    // second access address for lhld/shld
    logic [15:0] a2;
    logic        wr2;
    assign a2  = {hi_reg, lo_reg} + 16'd1;
    assign wr2 = 17'(a2) >= wp_reg;

    logic        mem_en;
    logic        mem_we;
    logic [15:0] mem_a;
    logic [7:0]  mem_d;

    always_comb
    begin
        mem_en = fire;
        mem_we = fire && mwr_in;
        mem_a  = maddr_in;
        mem_d  = mwd_in;
        if (s1_reg && st_reg == ST_IDLE && st_next != ST_IDLE) begin
            mem_en = 1'b1;
            mem_we = st_next == ST_WR2 && wr2;
            mem_a  = a2;
            mem_d  = h_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_en) begin
            if (mem_we)
                mem[mem_a[ADDR_BITS-1:0]] <= mem_d;
            rdat <= mem[mem_a[ADDR_BITS-1:0]];
        end
    end

    always_comb
    begin
        st_next = ST_IDLE;
        if (s1_reg && st_reg == ST_IDLE && cmd_reg == CMD_EXEC) begin
            if (cls_reg == OP_LHLD) st_next = ST_RD2;
            else if (cls_reg == OP_SHLD) st_next = ST_WR2;
        end
    end

    assign finish = s1_reg && st_next == ST_IDLE;

    // execute
    logic [7:0] mval, add_op, sum8;
    logic [8:0] sum;
    logic       cin;
    logic [4:0] fnew;

    assign mval = rdat;
    always_comb
    begin
        add_op = cls_reg == OP_ADI ? lo_reg :
                 reg_by_code(op_reg[2:0], b_reg, c_reg, d_reg, e_reg, h_reg,
                             l_reg, a_reg, mval);
        cin  = op_reg[3] & f_reg[0];
        sum  = {1'b0, a_reg} + {1'b0, add_op} + {8'h00, cin};
        sum8 = sum[7:0];
        fnew = {sum8[7], sum8 == 8'h00, ((a_reg ^ add_op ^ sum8) & 8'h10) != 8'h00,
                ~^sum8, sum[8]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_reg <= 1'b0;
            st_reg <= ST_IDLE;
            ov_reg <= 1'b0;
            wp_reg <= WP_RESET;
            {b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, a_reg} <= '0;
            f_reg  <= '0;
            pc_reg <= '0;
            sp_reg <= '0;
        end else begin
            if (cfg_we)
                wp_reg <= cfg_wdata;
            if (out_valid && out_ready)
                ov_reg <= 1'b0;
            if (fire) begin
                s1_reg    <= 1'b1;
                cmd_reg   <= command;
                op_reg    <= opcode;
                lo_reg    <= operand_low;
                hi_reg    <= operand_high;
                cls_reg   <= cls_in;
                ref1_reg  <= command == CMD_EXEC && !mwr_in
                             && ((cls_in == OP_STA || cls_in == OP_SHLD
                                  || cls_in == OP_STAX)
                                 || ((cls_in == OP_MOV || cls_in == OP_MVI)
                                     && dst_in == 3'd6
                                     && !(cls_in == OP_MOV && opcode[2:0] == 3'd6)));
            end
            if (s1_reg) begin
                st_reg <= st_next;
                if (st_reg == ST_IDLE)
                    first_reg <= rdat;
            end
            if (finish) begin
                s1_reg    <= 1'b0;
                ov_reg    <= 1'b1;
                o_rd_reg  <= cmd_reg == CMD_HRD ? rdat : 8'h00;
                o_ref_reg <= ref1_reg || (st_reg == ST_WR2 && !wr2);
                o_uns_reg <= cmd_reg == CMD_EXEC && cls_reg == OP_UNSUP;
                if (cmd_reg == CMD_EXEC) begin
                    pc_reg <= pc_reg + 16'(op_len(cls_reg));
                    case (cls_reg)
                        OP_MOV, OP_MVI: begin
                            logic [7:0] v;
                            v = cls_reg == OP_MVI ? lo_reg :
                                reg_by_code(op_reg[2:0], b_reg, c_reg, d_reg, e_reg,
                                            h_reg, l_reg, a_reg, mval);
                            case (op_reg[5:3])
                                3'd0: b_reg <= v;
                                3'd1: c_reg <= v;
                                3'd2: d_reg <= v;
                                3'd3: e_reg <= v;
                                3'd4: h_reg <= v;
                                3'd5: l_reg <= v;
                                3'd7: a_reg <= v;
                                default: ;
                            endcase
                        end
                        OP_LXI: begin
                            case (op_reg[5:4])
                                2'd0: {b_reg, c_reg} <= {hi_reg, lo_reg};
                                2'd1: {d_reg, e_reg} <= {hi_reg, lo_reg};
                                2'd2: {h_reg, l_reg} <= {hi_reg, lo_reg};
                                default: sp_reg <= {hi_reg, lo_reg};
                            endcase
                        end
                        OP_LDA, OP_LDAX: a_reg <= mval;
                        OP_LHLD: if (st_reg == ST_RD2)
                        begin
                            l_reg <= first_reg;
                            h_reg <= rdat;
                        end
                        OP_XCHG: begin
                            {h_reg, l_reg} <= {d_reg, e_reg};
                            {d_reg, e_reg} <= {h_reg, l_reg};
                        end
                        OP_ADD, OP_ADI: begin
                            a_reg <= sum8;
                            f_reg <= fnew;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    assign out_valid       = ov_reg;
    assign accumulator     = a_reg;
    assign flags           = f_reg;
    assign program_counter = pc_reg;
    assign pair_bc         = bc;
    assign pair_de         = de;
    assign pair_hl         = hl;
    assign read_data       = o_rd_reg;
    assign write_refused   = o_ref_reg;
    assign unsupported     = o_uns_reg;
endmodule
